// ===== rtl/assert_macros.svh =====
// assertion macros shared by the deframer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds in this cycle -> consequent holds in the same cycle
`define CHK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds in this cycle -> consequent holds in the next cycle
`define CHK_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mdd_pkg.sv =====
// types and constants of the frame deframer
package mdd_pkg;

  localparam int VERSION_LEN      = 1;
  localparam int MAGIC_LEN        = 4;
  localparam int BLOCK_LEN        = 8;
  localparam int LENGTH_FIELD_LEN = 4;
  localparam int SEQ_LEN          = 4;
  localparam int KEY_BYTE_POS     = 0;

  localparam int HOLD_DEPTH = 7;
  localparam int HOLD_W     = $clog2(HOLD_DEPTH + 1);
  localparam int PEND_W     = $clog2(HOLD_DEPTH + 3);
  localparam int MOD_W      = $clog2(BLOCK_LEN);
  localparam int CNT_W      = 31;
  localparam int LEN_W      = 8 * LENGTH_FIELD_LEN;

  // key bytes that get remapped (zero and KEY_SUB_BYTE), and the bias added to them
  localparam logic [7:0] KEY_SUB_BYTE = 8'd32;
  localparam logic [7:0] KEY_BIAS     = 8'd3;

  typedef enum logic [3:0] {
    ST_OK            = 4'd0,
    ST_BAD_VERSION   = 4'd1,
    ST_SHORT_VERSION = 4'd2,
    ST_SHORT_MAGIC   = 4'd3,
    ST_SHORT_IV      = 4'd4,
    ST_SHORT_LENGTH  = 4'd5,
    ST_NEG_LENGTH    = 4'd6,
    ST_SHORT_NAME    = 4'd7,
    ST_SHORT_SEQ     = 4'd8,
    ST_BAD_BLOCK     = 4'd9
  } status_t;

  typedef enum logic [7:0] {
    PH_VERSION = 8'b0000_0001,
    PH_MAGIC   = 8'b0000_0010,
    PH_IV      = 8'b0000_0100,
    PH_LENGTH  = 8'b0000_1000,
    PH_NAME    = 8'b0001_0000,
    PH_SEQ     = 8'b0010_0000,
    PH_PAYLOAD = 8'b0100_0000,
    PH_DISCARD = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_end;
    logic [3:0] status;
  } res_item_t;

  // everything one input item hands to the result sequencer
  typedef struct packed {
    logic                           rel_valid;
    logic [7:0]                     rel_byte;
    logic                           fin;
    logic [HOLD_W-1:0]              keep;
    status_t                        status;
    logic [HOLD_DEPTH-1:0][7:0]     hold;
  } bundle_t;

endpackage

// ===== rtl/mdd_core.sv =====
// field parser, header key xor and trailing hold buffer
module mdd_core
  import mdd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  in_item_t   item,
  input  logic [7:0] expected_version,
  output bundle_t    bundle
);

  `include "assert_macros.svh"

  phase_t                     phase, phase_next;
  logic [CNT_W-1:0]           cnt, cnt_next;
  logic [7:0]                 key, key_next;
  logic [LEN_W-1:0]           len, len_next;
  logic [MOD_W-1:0]           pmod, pmod_next;
  status_t                    err, err_next;
  logic [HOLD_W-1:0]          hold_count, count_after;
  logic [HOLD_DEPTH-1:0][7:0] hold, hold_after;

  logic [CNT_W:0]   cnt_plus;
  logic [LEN_W-1:0] len_shift;
  logic [7:0]       b, bx;
  logic             push, full;
  logic [7:0]       pbyte;
  status_t          st;
  logic [HOLD_W-1:0] keep;

  assign b         = item.in_byte;
  assign bx        = item.in_byte ^ key;
  assign cnt_plus  = {1'b0, cnt} + (CNT_W + 1)'(1);
  assign len_shift = {len[LEN_W-9:0], bx};

  always_comb begin
    phase_next = phase;
    cnt_next   = cnt;
    key_next   = key;
    len_next   = len;
    pmod_next  = pmod;
    err_next   = err;
    push       = 1'b0;
    pbyte      = b;
    case (phase)
      PH_VERSION: begin
        if (b != expected_version) begin
          err_next   = ST_BAD_VERSION;
          phase_next = PH_DISCARD;
        end else begin
          phase_next = PH_MAGIC;
          cnt_next   = '0;
        end
      end
      PH_MAGIC: begin
        push     = 1'b1;
        cnt_next = cnt_plus[CNT_W-1:0];
        if (cnt_plus >= (CNT_W + 1)'(MAGIC_LEN)) begin
          phase_next = PH_IV;
          cnt_next   = '0;
        end
      end
      PH_IV: begin
        if (cnt == CNT_W'(KEY_BYTE_POS)) begin
          key_next = (b == 8'd0 || b == KEY_SUB_BYTE) ? b + KEY_BIAS : b;
        end
        cnt_next = cnt_plus[CNT_W-1:0];
        if (cnt_plus >= (CNT_W + 1)'(BLOCK_LEN)) begin
          phase_next = PH_LENGTH;
          cnt_next   = '0;
          len_next   = '0;
        end
      end
      PH_LENGTH: begin
        push     = 1'b1;
        pbyte    = bx;
        len_next = len_shift;
        cnt_next = cnt_plus[CNT_W-1:0];
        if (cnt_plus >= (CNT_W + 1)'(LENGTH_FIELD_LEN)) begin
          cnt_next = '0;
          if (len_shift[LEN_W-1]) begin
            err_next   = ST_NEG_LENGTH;
            phase_next = PH_DISCARD;
          end else begin
            phase_next = (len_shift == '0) ? PH_SEQ : PH_NAME;
          end
        end
      end
      PH_NAME: begin
        push     = 1'b1;
        pbyte    = bx;
        cnt_next = cnt_plus[CNT_W-1:0];
        if (cnt_plus >= len) begin
          phase_next = PH_SEQ;
          cnt_next   = '0;
        end
      end
      PH_SEQ: begin
        push     = 1'b1;
        pbyte    = bx;
        cnt_next = cnt_plus[CNT_W-1:0];
        if (cnt_plus >= (CNT_W + 1)'(SEQ_LEN)) begin
          phase_next = PH_PAYLOAD;
          cnt_next   = '0;
          pmod_next  = '0;
        end
      end
      PH_PAYLOAD: begin
        push      = 1'b1;
        pmod_next = pmod + MOD_W'(1);
      end
      default: begin
      end
    endcase
  end

  // hold buffer: the oldest byte leaves once all entries are taken
  assign full = (hold_count >= HOLD_W'(HOLD_DEPTH));

  always_comb begin
    hold_after  = hold;
    count_after = hold_count;
    if (push) begin
      if (full) begin
        hold_after                 = hold >> 8;
        hold_after[HOLD_DEPTH-1]   = pbyte;
        count_after                = HOLD_W'(HOLD_DEPTH);
      end else begin
        hold_after[hold_count]     = pbyte;
        count_after                = hold_count + HOLD_W'(1);
      end
    end
  end

  always_comb begin
    case (phase_next)
      PH_VERSION: st = ST_SHORT_VERSION;
      PH_MAGIC:   st = ST_SHORT_MAGIC;
      PH_IV:      st = ST_SHORT_IV;
      PH_LENGTH:  st = ST_SHORT_LENGTH;
      PH_NAME:    st = ST_SHORT_NAME;
      PH_SEQ:     st = ST_SHORT_SEQ;
      PH_PAYLOAD: st = (pmod_next != '0) ? ST_BAD_BLOCK : ST_OK;
      default:    st = err_next;
    endcase
  end

  // bytes kept at frame end: up to and including the newest zero byte
  always_comb begin
    keep = '0;
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      if (HOLD_W'(i) < count_after && hold_after[i] == 8'h00) begin
        keep = HOLD_W'(i + 1);
      end
    end
  end

  // the flush happens only on the last byte of a good frame
  always_comb begin
    bundle.rel_valid = push & full;
    bundle.rel_byte  = hold[0];
    bundle.fin       = item.in_last;
    bundle.status    = st;
    bundle.keep      = (item.in_last && st == ST_OK) ? keep : '0;
    bundle.hold      = hold_after;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_VERSION;
      cnt        <= '0;
      key        <= '0;
      len        <= '0;
      pmod       <= '0;
      err        <= ST_OK;
      hold_count <= '0;
    end else if (fire) begin
      if (item.in_last) begin
        phase      <= PH_VERSION;
        cnt        <= '0;
        key        <= '0;
        len        <= '0;
        pmod       <= '0;
        err        <= ST_OK;
        hold_count <= '0;
      end else begin
        phase      <= phase_next;
        cnt        <= cnt_next;
        key        <= key_next;
        len        <= len_next;
        pmod       <= pmod_next;
        err        <= err_next;
        hold_count <= count_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      hold <= hold_after;
    end
  end

  `CHK_NXT(a_frame_clears, fire && item.in_last, phase == PH_VERSION && hold_count == '0, "frame end did not clear state")
  `CHK_IMP(a_hold_phase, hold_count != '0, phase != PH_VERSION, "held bytes outside a frame")

endmodule

// ===== rtl/mdd_emit.sv =====
// result sequencer: released byte, trimmed flush, then frame status
module mdd_emit
  import mdd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  bundle_t   bundle,
  output logic      free,
  output logic      res_valid,
  input  logic      res_stall,
  output res_item_t res
);

  `include "assert_macros.svh"

  logic                       pend_rel;
  logic [7:0]                 rel_byte;
  logic [HOLD_DEPTH-1:0][7:0] flush_buf;
  logic [HOLD_W-1:0]          flush_left;
  logic                       pend_stat;
  status_t                    stat;

  logic [PEND_W-1:0] pend_cnt;
  logic              take;

  assign pend_cnt  = PEND_W'(pend_rel) + PEND_W'(flush_left) + PEND_W'(pend_stat);
  assign res_valid = (pend_cnt != '0);
  assign take      = res_valid & ~res_stall;
  assign free      = (pend_cnt == '0) || (pend_cnt == PEND_W'(1) && take);

  always_comb begin
    if (pend_rel) begin
      res = '{out_byte: rel_byte, byte_valid: 1'b1, frame_end: 1'b0, status: ST_OK};
    end else if (flush_left != '0) begin
      res = '{out_byte: flush_buf[0], byte_valid: 1'b1, frame_end: 1'b0, status: ST_OK};
    end else begin
      res = '{out_byte: 8'h00, byte_valid: 1'b0, frame_end: pend_stat, status: stat};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_rel   <= 1'b0;
      flush_left <= '0;
      pend_stat  <= 1'b0;
    end else if (load) begin
      pend_rel   <= bundle.rel_valid;
      flush_left <= bundle.keep;
      pend_stat  <= bundle.fin;
    end else if (take) begin
      if (pend_rel) begin
        pend_rel <= 1'b0;
      end else if (flush_left != '0) begin
        flush_left <= flush_left - HOLD_W'(1);
      end else begin
        pend_stat <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rel_byte  <= bundle.rel_byte;
      flush_buf <= bundle.hold;
      stat      <= bundle.status;
    end else if (take && !pend_rel && flush_left != '0) begin
      flush_buf <= flush_buf >> 8;
    end
  end

  `CHK_IMP(a_flush_at_end, flush_left != '0, pend_stat, "flush without a closing status")
  `CHK_NXT(a_end_drains, take && res.frame_end && !load, pend_cnt == '0, "results left after status")

endmodule

// ===== rtl/message_deframe_decrypt.sv =====
// top level of the streaming frame deframer with header key decode
// throughput: one byte per cycle while res_stall is low; a frame's last byte holds the
//   input while up to nine results drain (one released byte, seven flushed bytes, the status)
// the header path is an input register, one parse step and a result sequencer
// reset: synchronous, active high; clears all frame state and expected_version
module message_deframe_decrypt
  import mdd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // input byte channel
  input  logic       item_valid,
  output logic       item_stall,
  input  in_item_t   item,
  // result channel
  output logic       res_valid,
  input  logic       res_stall,
  output res_item_t  res,
  // version register write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0] expected_version;

  // input register in front of the parser
  logic     in_q_valid;
  in_item_t in_q;

  // the parser fires when the sequencer can take its whole bundle
  logic    emit_free;
  logic    fire;
  bundle_t bundle;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= '0;
    end else if (cfg_valid && cfg_ready) begin
      expected_version <= cfg_data;
    end
  end

  // hold the input only while a captured item waits for the parser
  assign fire       = in_q_valid & emit_free;
  assign item_stall = in_q_valid & ~emit_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!item_stall) begin
      in_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_q <= item;
    end
  end

  // phase tracking, key decode and the trailing hold buffer
  mdd_core u_core (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire),
    .item             (in_q),
    .expected_version (expected_version),
    .bundle           (bundle)
  );

  // emits each bundle as a run of result items
  mdd_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .bundle    (bundle),
    .free      (emit_free),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// ===== sim/tb.sv =====
// testbench of the frame deframer: random and directed frames checked by a scoreboard
`timescale 1ns / 100ps

module tb;
  import mdd_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int HOLDOFF_CYCLES = 150;
  localparam int SETTLE_CYCLES  = 10;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASE_BYTES    = 60;

  // expected results of the deframer, kept in step with the accepted bytes
  class frame_scoreboard;
    logic [7:0]  version;
    phase_t      stage;
    int unsigned fcount;
    logic [7:0]  hkey;
    logic [31:0] nlen;
    logic [2:0]  pmod;
    logic [7:0]  held [HOLD_DEPTH];
    int          hcnt;
    status_t     err;
    res_item_t   pending [$];
    int          errors;

    function new();
      version = 8'h00;
      errors  = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      stage  = PH_VERSION;
      fcount = 0;
      hkey   = 8'h00;
      nlen   = 32'h0;
      pmod   = 3'd0;
      hcnt   = 0;
      err    = ST_OK;
    endfunction

    function void set_version(logic [7:0] v);
      version = v;
    endfunction

    function void emit(logic [7:0] b, logic v, logic e, status_t s);
      pending.push_back('{out_byte: b, byte_valid: v, frame_end: e, status: s});
    endfunction

    // decoded bytes pass a seven-deep hold buffer; a full buffer releases its oldest
    function void hold_byte(logic [7:0] b);
      if (hcnt >= HOLD_DEPTH) begin
        emit(held[0], 1'b1, 1'b0, ST_OK);
        for (int i = 0; i < HOLD_DEPTH - 1; i++) held[i] = held[i + 1];
        hcnt = HOLD_DEPTH - 1;
      end
      held[hcnt] = b;
      hcnt++;
    endfunction

    function void note_byte(in_item_t it);
      logic [7:0] b;
      logic [7:0] x;
      status_t    st;
      int         keep;
      b = it.in_byte;
      case (stage)
        PH_VERSION: begin
          if (b != version) begin
            err   = ST_BAD_VERSION;
            stage = PH_DISCARD;
          end else begin
            stage  = PH_MAGIC;
            fcount = 0;
          end
        end
        PH_MAGIC: begin
          hold_byte(b);
          fcount++;
          if (fcount >= MAGIC_LEN) begin
            stage  = PH_IV;
            fcount = 0;
          end
        end
        PH_IV: begin
          if (fcount == KEY_BYTE_POS)
            hkey = (b == 8'h00 || b == KEY_SUB_BYTE) ? b + KEY_BIAS : b;
          fcount++;
          if (fcount >= BLOCK_LEN) begin
            stage  = PH_LENGTH;
            fcount = 0;
            nlen   = 32'h0;
          end
        end
        PH_LENGTH: begin
          x = b ^ hkey;
          hold_byte(x);
          nlen = {nlen[23:0], x};
          fcount++;
          if (fcount >= LENGTH_FIELD_LEN) begin
            fcount = 0;
            if (nlen[31]) begin
              err   = ST_NEG_LENGTH;
              stage = PH_DISCARD;
            end else if (nlen == 0) begin
              stage = PH_SEQ;
            end else begin
              stage = PH_NAME;
            end
          end
        end
        PH_NAME: begin
          hold_byte(b ^ hkey);
          fcount++;
          if (fcount >= nlen) begin
            stage  = PH_SEQ;
            fcount = 0;
          end
        end
        PH_SEQ: begin
          hold_byte(b ^ hkey);
          fcount++;
          if (fcount >= SEQ_LEN) begin
            stage  = PH_PAYLOAD;
            fcount = 0;
            pmod   = 3'd0;
          end
        end
        PH_PAYLOAD: begin
          hold_byte(b);
          pmod = pmod + 3'd1;
        end
        default: ;
      endcase

      if (it.in_last) begin
        case (stage)
          PH_VERSION: st = ST_SHORT_VERSION;
          PH_MAGIC:   st = ST_SHORT_MAGIC;
          PH_IV:      st = ST_SHORT_IV;
          PH_LENGTH:  st = ST_SHORT_LENGTH;
          PH_NAME:    st = ST_SHORT_NAME;
          PH_SEQ:     st = ST_SHORT_SEQ;
          PH_PAYLOAD: begin
            if (pmod != 0) st = ST_BAD_BLOCK;
            else st = ST_OK;
          end
          default:    st = err;
        endcase
        // a good frame flushes its held bytes minus the trailing nonzero run
        if (st == ST_OK) begin
          keep = hcnt;
          while (keep > 0 && held[keep - 1] != 8'h00) keep--;
          for (int i = 0; i < keep; i++) emit(held[i], 1'b1, 1'b0, ST_OK);
        end
        emit(8'h00, 1'b0, 1'b1, st);
        clear_frame();
      end
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t: %s", $time, msg);
    endfunction

    function void check_result(res_item_t got);
      res_item_t exp;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected result byte=%02h valid=%0b end=%0b status=%0d",
                       got.out_byte, got.byte_valid, got.frame_end, got.status));
        return;
      end
      exp = pending.pop_front();
      if (got.out_byte !== exp.out_byte || got.byte_valid !== exp.byte_valid ||
          got.frame_end !== exp.frame_end || got.status !== exp.status)
        flag($sformatf({"mismatch: expected byte=%02h valid=%0b end=%0b status=%0d,",
                        " got byte=%02h valid=%0b end=%0b status=%0d"},
                       exp.out_byte, exp.byte_valid, exp.frame_end, exp.status,
                       got.out_byte, got.byte_valid, got.frame_end, got.status));
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  in_item_t   item       = '0;
  logic       res_valid;
  logic       res_stall  = 1'b0;
  res_item_t  res;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data   = 8'h00;

  int   bytes_in = 0;
  int   cycles   = 0;
  logic held_off = 1'b0;
  logic calm;

  frame_scoreboard sb = new();

  // a window of bytes where neither side idles
  assign calm = (bytes_in >= 200) && (bytes_in < 280);

  message_deframe_decrypt uut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_result(res);
  end

  // result side: random stalls, plus one long hold-off while bytes keep coming
  initial begin : result_drain
    forever begin
      @(posedge clk);
      if (!held_off && bytes_in >= 120) begin
        held_off = 1'b1;
        res_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end
      res_stall <= !calm && ($urandom_range(0, 99) < 11);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    it.in_byte = b;
    it.in_last = last;
    if (!calm && $urandom_range(0, 99) < 11) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_byte(it);
    bytes_in++;
  endtask

  // mostly well-formed frames with random content; some broken or cut short
  task automatic send_frame(input logic [7:0] ver);
    logic [7:0]  frame [$];
    logic [7:0]  kb;
    logic [7:0]  k;
    logic [31:0] nl;
    int          n;
    int          pay;
    int          len;
    int          pick;
    if ($urandom_range(0, 99) < 8) frame.push_back(ver ^ 8'($urandom_range(1, 255)));
    else frame.push_back(ver);
    repeat (MAGIC_LEN) frame.push_back(8'($urandom_range(0, 255)));
    pick = $urandom_range(0, 4);
    case (pick)
      0:       kb = 8'h00;
      1:       kb = KEY_SUB_BYTE;
      2:       kb = 8'hFF;
      default: kb = 8'($urandom_range(0, 255));
    endcase
    k = (kb == 8'h00 || kb == KEY_SUB_BYTE) ? kb + KEY_BIAS : kb;
    for (int i = 0; i < BLOCK_LEN; i++)
      frame.push_back((i == KEY_BYTE_POS) ? kb : 8'($urandom_range(0, 255)));
    pick = $urandom_range(0, 99);
    if (pick < 8) nl = {1'b1, 31'($urandom())};
    else if (pick < 14) nl = {1'b0, 31'($urandom())} | 32'h0000_0100;
    else nl = $urandom_range(0, 6);
    for (int i = LENGTH_FIELD_LEN - 1; i >= 0; i--) frame.push_back(nl[8*i +: 8] ^ k);
    n = (nl <= 6) ? int'(nl) : $urandom_range(0, 6);
    repeat (n) frame.push_back(8'($urandom_range(0, 255)));
    repeat (SEQ_LEN) frame.push_back(8'($urandom_range(0, 255)));
    pay = BLOCK_LEN * $urandom_range(0, 3);
    if ($urandom_range(0, 99) < 20) pay += $urandom_range(1, BLOCK_LEN - 1);
    // zero-heavy payload so the trailing trim sees both stop cases
    repeat (pay)
      frame.push_back(($urandom_range(0, 99) < 30) ? 8'h00 : 8'($urandom_range(1, 255)));
    len = frame.size();
    if ($urandom_range(0, 99) < 15) len = $urandom_range(1, len);
    for (int i = 0; i < len; i++) send_byte(frame[i], i == len - 1);
  endtask

  // sender waits until every expected item has come back, then lets the block settle
  task automatic settle();
    item_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_version(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_version(v);
  endtask

  initial begin : stimulus
    logic [7:0] versions [4];
    int         target;
    versions = '{8'hFF, 8'($urandom_range(1, 254)), 8'h00, KEY_SUB_BYTE};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register still at its reset value of zero
    send_byte(8'hFF, 1'b1);                 // bad version, one-byte frame
    send_byte(8'h00, 1'b1);                 // version only, magic missing
    send_byte(8'h00, 1'b0);                 // frame cut inside the iv
    repeat (MAGIC_LEN) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(KEY_SUB_BYTE, 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    settle();
    write_version(8'h5A);
    send_byte(8'h00, 1'b0);                 // bad version, rest ignored
    repeat (3) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'h5A, 1'b1);

    foreach (versions[p]) begin
      settle();
      write_version(versions[p]);
      target = bytes_in + PHASE_BYTES;
      while (bytes_in < target) send_frame(versions[p]);
    end

    settle();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
